@@ hw/rtl/bld_pkg.sv @@
package bld_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int MAX_ITEMS   = 256;
  localparam int MAX_GROUPS  = 16;
  localparam int WEIGHT_BITS = 16;

  localparam int SW   = 6;          // sample index bits
  localparam int IW   = 8;          // item index bits
  localparam int GW   = 4;          // group label bits
  localparam int CW   = 9;          // count bits
  localparam int TW   = 22;         // total weight bits
  localparam int DW   = 35;         // scaled delta bits
  localparam int JAW  = SW + 2*GW;  // joint count address bits
  localparam int LAW  = SW + IW;    // sample label address bits

  localparam logic [2:0] MODE_LD_LABEL = 3'd0;
  localparam logic [2:0] MODE_LD_WEIGHT = 3'd1;
  localparam logic [2:0] MODE_LD_DEC   = 3'd2;
  localparam logic [2:0] MODE_REBUILD  = 3'd3;
  localparam logic [2:0] MODE_EVAL     = 3'd4;
  localparam logic [2:0] MODE_MOVE     = 3'd5;

  // Joint count write operations.
  localparam logic [2:0] JW_NONE  = 3'd0;
  localparam logic [2:0] JW_CLR   = 3'd1;
  localparam logic [2:0] JW_DEC_A = 3'd2;
  localparam logic [2:0] JW_INC_A = 3'd3;
  localparam logic [2:0] JW_INC_B = 3'd4;

  // Kinds of result.
  localparam logic [1:0] EMIT_OK   = 2'd0;
  localparam logic [1:0] EMIT_ERR  = 2'd1;
  localparam logic [1:0] EMIT_ZERO = 2'd2;
  localparam logic [1:0] EMIT_ACC  = 2'd3;

  // Group size read port selection.
  localparam logic [1:0] SZA_HGRP = 2'd0;
  localparam logic [1:0] SZA_DEC  = 2'd1;
  localparam logic [1:0] SZA_GRP  = 2'd2;

  localparam int REG_NUM_SAMPLES = 0;
  localparam int REG_NUM_ITEMS   = 1;
  localparam int REG_NUM_GROUPS  = 2;

  typedef struct packed {
    logic            cap;
    logic [SW-1:0]   s;
    logic            use_h;
    logic [IW-1:0]   h_item;
    logic            rd_lab;
    logic            rd_wt;
    logic            rd_dec;
    logic            wr_lab;
    logic            wr_wt;
    logic            wr_dec;
    logic            rd_joint;
    logic            b_move;
    logic [2:0]      jw;
    logic [JAW-1:0]  clr_addr;
    logic [1:0]      sz_addr;
    logic            sz_clr;
    logic            sz_move;
    logic            sz_inc;
    logic            ld_g;
    logic            tot_clr;
    logic            tot_add;
    logic            base;
    logic            acc_init;
    logic            issue;
    logic            emit;
    logic [1:0]      emit_kind;
    logic            last;
    logic [GW-1:0]   hgrp;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       lab_bad;
    logic       si_bad;
    logic       it_grp_bad;
    logic       it_bad;
    logic       g_bad;
    logic       g_eq_grp;
    logic       h_is_g;
    logic       size_zero;
    logic       pipe_idle;
  } sts_t;

endpackage

@@ hw/rtl/bld_dp.sv @@
module bld_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  bld_pkg::cmd_t                   cmd,
  input  logic [2:0]                      mode,
  input  logic [bld_pkg::SW-1:0]          sample_index,
  input  logic [bld_pkg::IW-1:0]          item_index,
  input  logic [bld_pkg::GW-1:0]          group,
  input  logic [15:0]                     weight,
  input  logic [6:0]                      ns,
  input  logic [8:0]                      ni,
  input  logic [4:0]                      ng,
  output bld_pkg::sts_t                   sts,
  output logic                            valid,
  output logic [bld_pkg::GW-1:0]          target_group,
  output logic signed [bld_pkg::DW-1:0]   delta_scaled,
  output logic [bld_pkg::TW-1:0]          total_weight,
  output logic                            status,
  output logic                            last
);

  localparam int SW  = bld_pkg::SW;
  localparam int IW  = bld_pkg::IW;
  localparam int GW  = bld_pkg::GW;
  localparam int CW  = bld_pkg::CW;
  localparam int TW  = bld_pkg::TW;
  localparam int DW  = bld_pkg::DW;
  localparam int JAW = bld_pkg::JAW;
  localparam int LAW = bld_pkg::LAW;
  localparam int WB  = bld_pkg::WEIGHT_BITS;

  logic [2:0]    mode_r;
  logic [SW-1:0] si_r;
  logic [IW-1:0] it_r;
  logic [GW-1:0] grp_r;
  logic [WB-1:0] w_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r <= mode;
      si_r   <= sample_index;
      it_r   <= item_index;
      grp_r  <= group;
      w_r    <= weight[WB-1:0];
    end
  end

  logic [IW-1:0] item_sel;
  assign item_sel = cmd.use_h ? cmd.h_item : it_r;

  // Sample labels.
  logic [GW-1:0] lab_mem [0:(1<<LAW)-1];
  logic [GW-1:0] lab_q;
  always_ff @(posedge clk) begin
    if (cmd.wr_lab) begin
      lab_mem[{si_r, it_r}] <= grp_r;
    end
    if (cmd.rd_lab) begin
      lab_q <= lab_mem[{cmd.s, item_sel}];
    end
  end

  // Sample weights.
  logic [WB-1:0] wt_mem [0:(1<<SW)-1];
  logic [WB-1:0] wt_q;
  always_ff @(posedge clk) begin
    if (cmd.wr_wt) begin
      wt_mem[si_r] <= w_r;
    end
    if (cmd.rd_wt) begin
      wt_q <= wt_mem[cmd.s];
    end
  end

  // Decision labels.
  logic [GW-1:0] dec_mem [0:(1<<IW)-1];
  logic [GW-1:0] dec_q;
  always_ff @(posedge clk) begin
    if (cmd.wr_dec) begin
      dec_mem[it_r] <= grp_r;
    end
    if (cmd.rd_dec) begin
      dec_q <= dec_mem[item_sel];
    end
  end

  // Evaluation pipeline valid bits.
  logic v0, v1, v2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= cmd.issue;
      v1 <= v0;
      v2 <= v1;
    end
  end

  logic [SW-1:0] s_d;
  logic [GW-1:0] g_reg;
  logic [CW-1:0] ng_reg;
  always_ff @(posedge clk) begin
    s_d <= cmd.s;
  end

  // Joint counts: two read ports, one write port.
  logic [CW-1:0]  jmem [0:(1<<JAW)-1];
  logic [CW-1:0]  qa, qb;
  logic [JAW-1:0] ja, jb, ja_n, jb_n;
  logic           jrd;

  assign jrd  = cmd.rd_joint | v0;
  assign ja_n = {s_d, g_reg, lab_q};
  assign jb_n = {s_d, (cmd.b_move ? grp_r : cmd.hgrp), lab_q};

  always_ff @(posedge clk) begin
    if (jrd) begin
      qa <= jmem[ja_n];
      qb <= jmem[jb_n];
      ja <= ja_n;
      jb <= jb_n;
    end
    case (cmd.jw)
      bld_pkg::JW_CLR:   jmem[cmd.clr_addr] <= '0;
      bld_pkg::JW_DEC_A: jmem[ja] <= qa - CW'(1);
      bld_pkg::JW_INC_A: jmem[ja] <= qa + CW'(1);
      bld_pkg::JW_INC_B: jmem[jb] <= qb + CW'(1);
      default: ;
    endcase
  end

  // Group sizes, one read port.
  logic [CW-1:0] sizes [0:(1<<GW)-1];
  logic [GW-1:0] sz_ra;
  logic [CW-1:0] sz_q;

  always_comb begin
    case (cmd.sz_addr)
      bld_pkg::SZA_DEC: sz_ra = dec_q;
      bld_pkg::SZA_GRP: sz_ra = grp_r;
      default:          sz_ra = cmd.hgrp;
    endcase
  end
  assign sz_q = sizes[sz_ra];

  always_ff @(posedge clk) begin
    if (rst || cmd.sz_clr) begin
      for (int i = 0; i < (1<<GW); i++) begin
        sizes[i] <= '0;
      end
    end else if (cmd.sz_move) begin
      sizes[g_reg] <= ng_reg - CW'(1);
      sizes[grp_r] <= sz_q + CW'(1);
    end else if (cmd.sz_inc) begin
      sizes[sz_ra] <= sz_q + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_g) begin
      g_reg  <= dec_q;
      ng_reg <= sz_q;
    end
  end

  // Total weight.
  logic [TW-1:0] total;
  always_ff @(posedge clk) begin
    if (rst || cmd.tot_clr) begin
      total <= '0;
    end else if (cmd.tot_add) begin
      total <= total + TW'(wt_q);
    end
  end

  // Delta arithmetic.
  logic signed [10:0]   nd;
  logic signed [33:0]   base_prod;
  logic signed [9:0]    diff;
  logic [WB-1:0]        wt_d;
  logic signed [WB+10:0] prod;
  logic signed [DW-1:0] acc;

  assign nd   = $signed({2'b00, sz_q}) - $signed({2'b00, ng_reg}) - 11'sd1;
  assign diff = $signed({1'b0, qa}) - $signed({1'b0, qb});

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      base_prod <= $signed({1'b0, total}) * nd;
    end
    if (v0) begin
      wt_d <= wt_q;
    end
    if (v1) begin
      prod <= diff * $signed({1'b0, wt_d});
    end
    if (cmd.acc_init) begin
      acc <= DW'(base_prod);
    end else if (v2) begin
      acc <= acc + DW'($signed({prod, 1'b0}));
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      total_weight <= total;
      status       <= (cmd.emit_kind == bld_pkg::EMIT_ERR);
      case (cmd.emit_kind)
        bld_pkg::EMIT_ZERO: begin
          target_group <= cmd.hgrp;
          delta_scaled <= '0;
          last         <= cmd.last;
        end
        bld_pkg::EMIT_ACC: begin
          target_group <= cmd.hgrp;
          delta_scaled <= acc;
          last         <= cmd.last;
        end
        default: begin
          target_group <= '0;
          delta_scaled <= '0;
          last         <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sts.mode       = mode_r;
    sts.si_bad     = {1'b0, si_r} >= ns;
    sts.it_bad     = {1'b0, it_r} >= ni;
    sts.it_grp_bad = sts.it_bad || ({1'b0, grp_r} >= ng);
    sts.lab_bad    = sts.si_bad || sts.it_grp_bad;
    sts.g_bad      = {1'b0, dec_q} >= ng;
    sts.g_eq_grp   = dec_q == grp_r;
    sts.h_is_g     = cmd.hgrp == g_reg;
    sts.size_zero  = sz_q == '0;
    sts.pipe_idle  = !(v0 || v1 || v2);
  end

endmodule

@@ hw/rtl/bld_ctrl.sv @@
module bld_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [6:0]    ns,
  input  logic [8:0]    ni,
  input  logic [4:0]    ng,
  input  bld_pkg::sts_t sts,
  output bld_pkg::cmd_t cmd,
  output logic          busy
);

  localparam int JAW = bld_pkg::JAW;

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_SUM_RD  = 5'd3;
  localparam logic [4:0] S_SUM_ADD = 5'd4;
  localparam logic [4:0] S_CHK     = 5'd5;
  localparam logic [4:0] S_MSZ     = 5'd6;
  localparam logic [4:0] S_MLAB    = 5'd7;
  localparam logic [4:0] S_MJRD    = 5'd8;
  localparam logic [4:0] S_MWA     = 5'd9;
  localparam logic [4:0] S_MWB     = 5'd10;
  localparam logic [4:0] S_RDEC    = 5'd11;
  localparam logic [4:0] S_RG      = 5'd12;
  localparam logic [4:0] S_RLAB    = 5'd13;
  localparam logic [4:0] S_RJRD    = 5'd14;
  localparam logic [4:0] S_RWA     = 5'd15;
  localparam logic [4:0] S_EGRP    = 5'd16;
  localparam logic [4:0] S_EBASE   = 5'd17;
  localparam logic [4:0] S_EINIT   = 5'd18;
  localparam logic [4:0] S_EISS    = 5'd19;
  localparam logic [4:0] S_EDRN    = 5'd20;
  localparam logic [4:0] S_EOUT    = 5'd21;
  localparam logic [4:0] S_DONE    = 5'd22;
  localparam logic [4:0] S_ERR     = 5'd23;

  logic [4:0]     state, state_next;
  logic [6:0]     s_cnt, s_cnt_next;
  logic [8:0]     h_cnt, h_cnt_next;
  logic [4:0]     g_cnt, g_cnt_next;
  logic [JAW-1:0] clr_cnt, clr_cnt_next;
  logic           rb, rb_next;
  logic           empty_seen, empty_seen_next;
  logic           g_last;

  assign busy   = state != S_IDLE;
  assign g_last = (g_cnt + 5'd1) == ng;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      s_cnt      <= '0;
      h_cnt      <= '0;
      g_cnt      <= '0;
      clr_cnt    <= '0;
      rb         <= 1'b0;
      empty_seen <= 1'b0;
    end else begin
      state      <= state_next;
      s_cnt      <= s_cnt_next;
      h_cnt      <= h_cnt_next;
      g_cnt      <= g_cnt_next;
      clr_cnt    <= clr_cnt_next;
      rb         <= rb_next;
      empty_seen <= empty_seen_next;
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.s           = s_cnt[bld_pkg::SW-1:0];
    cmd.h_item      = h_cnt[bld_pkg::IW-1:0];
    cmd.hgrp        = g_cnt[bld_pkg::GW-1:0];
    cmd.clr_addr    = clr_cnt;
    cmd.last        = g_last;
    state_next      = state;
    s_cnt_next      = s_cnt;
    h_cnt_next      = h_cnt;
    g_cnt_next      = g_cnt;
    clr_cnt_next    = clr_cnt;
    rb_next         = rb;
    empty_seen_next = empty_seen;

    case (state)
      S_CLR: begin
        cmd.jw       = bld_pkg::JW_CLR;
        clr_cnt_next = clr_cnt + JAW'(1);
        if (clr_cnt == '1) begin
          h_cnt_next = '0;
          state_next = rb ? S_RDEC : S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.cap = start;
        if (start) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        s_cnt_next = '0;
        case (sts.mode)
          bld_pkg::MODE_LD_LABEL: begin
            cmd.wr_lab = !sts.lab_bad;
            state_next = sts.lab_bad ? S_ERR : S_DONE;
          end
          bld_pkg::MODE_LD_WEIGHT: begin
            cmd.wr_wt   = !sts.si_bad;
            cmd.tot_clr = !sts.si_bad;
            state_next  = sts.si_bad ? S_ERR : S_SUM_RD;
          end
          bld_pkg::MODE_LD_DEC: begin
            cmd.wr_dec = !sts.it_grp_bad;
            state_next = sts.it_grp_bad ? S_ERR : S_DONE;
          end
          bld_pkg::MODE_REBUILD: begin
            cmd.sz_clr   = 1'b1;
            clr_cnt_next = '0;
            rb_next      = 1'b1;
            state_next   = S_CLR;
          end
          bld_pkg::MODE_EVAL, bld_pkg::MODE_MOVE: begin
            cmd.rd_dec = 1'b1;
            state_next = S_CHK;
          end
          default: state_next = S_ERR;
        endcase
      end
      S_SUM_RD: begin
        if (s_cnt == ns) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_wt  = 1'b1;
          state_next = S_SUM_ADD;
        end
      end
      S_SUM_ADD: begin
        cmd.tot_add = 1'b1;
        s_cnt_next  = s_cnt + 7'd1;
        state_next  = S_SUM_RD;
      end
      S_CHK: begin
        cmd.sz_addr     = bld_pkg::SZA_DEC;
        cmd.ld_g        = 1'b1;
        g_cnt_next      = '0;
        empty_seen_next = 1'b0;
        if (sts.mode == bld_pkg::MODE_EVAL) begin
          state_next = (sts.it_bad || sts.g_bad) ? S_ERR : S_EGRP;
        end else if (sts.it_grp_bad || sts.g_bad) begin
          state_next = S_ERR;
        end else if (sts.g_eq_grp) begin
          state_next = S_DONE;
        end else begin
          cmd.wr_dec = 1'b1;
          state_next = S_MSZ;
        end
      end
      S_MSZ: begin
        cmd.sz_addr = bld_pkg::SZA_GRP;
        cmd.sz_move = 1'b1;
        state_next  = S_MLAB;
      end
      S_MLAB: begin
        if (s_cnt == ns) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_lab = 1'b1;
          state_next = S_MJRD;
        end
      end
      S_MJRD: begin
        cmd.rd_joint = 1'b1;
        cmd.b_move   = 1'b1;
        state_next   = S_MWA;
      end
      S_MWA: begin
        cmd.jw     = bld_pkg::JW_DEC_A;
        state_next = S_MWB;
      end
      S_MWB: begin
        cmd.jw     = bld_pkg::JW_INC_B;
        s_cnt_next = s_cnt + 7'd1;
        state_next = S_MLAB;
      end
      S_RDEC: begin
        s_cnt_next = '0;
        if (h_cnt == ni) begin
          rb_next     = 1'b0;
          cmd.tot_clr = 1'b1;
          state_next  = S_SUM_RD;
        end else begin
          cmd.use_h  = 1'b1;
          cmd.rd_dec = 1'b1;
          state_next = S_RG;
        end
      end
      S_RG: begin
        cmd.sz_addr = bld_pkg::SZA_DEC;
        cmd.ld_g    = 1'b1;
        cmd.sz_inc  = 1'b1;
        state_next  = S_RLAB;
      end
      S_RLAB: begin
        cmd.use_h = 1'b1;
        if (s_cnt == ns) begin
          h_cnt_next = h_cnt + 9'd1;
          state_next = S_RDEC;
        end else begin
          cmd.rd_lab = 1'b1;
          state_next = S_RJRD;
        end
      end
      S_RJRD: begin
        cmd.rd_joint = 1'b1;
        state_next   = S_RWA;
      end
      S_RWA: begin
        cmd.jw     = bld_pkg::JW_INC_A;
        s_cnt_next = s_cnt + 7'd1;
        state_next = S_RLAB;
      end
      S_EGRP: begin
        cmd.sz_addr = bld_pkg::SZA_HGRP;
        if (sts.size_zero) begin
          empty_seen_next = 1'b1;
        end
        if ((!sts.size_zero || !empty_seen) && !sts.h_is_g) begin
          state_next = S_EBASE;
        end else begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = bld_pkg::EMIT_ZERO;
          g_cnt_next    = g_cnt + 5'd1;
          if (g_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EBASE: begin
        cmd.sz_addr = bld_pkg::SZA_HGRP;
        cmd.base    = 1'b1;
        state_next  = S_EINIT;
      end
      S_EINIT: begin
        cmd.acc_init = 1'b1;
        s_cnt_next   = '0;
        state_next   = S_EISS;
      end
      S_EISS: begin
        if (s_cnt == ns) begin
          state_next = S_EDRN;
        end else begin
          cmd.rd_lab = 1'b1;
          cmd.rd_wt  = 1'b1;
          cmd.issue  = 1'b1;
          s_cnt_next = s_cnt + 7'd1;
        end
      end
      S_EDRN: begin
        if (sts.pipe_idle) begin
          state_next = S_EOUT;
        end
      end
      S_EOUT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = bld_pkg::EMIT_ACC;
        g_cnt_next    = g_cnt + 5'd1;
        state_next    = g_last ? S_IDLE : S_EGRP;
      end
      S_DONE: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = bld_pkg::EMIT_OK;
        state_next    = S_IDLE;
      end
      S_ERR: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = bld_pkg::EMIT_ERR;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_reset_clears: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> (state == S_CLR && clr_cnt == '0))
    else $error("clearing pass does not start after reset");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (state == S_DISP))
    else $error("accepted item not dispatched");

  a_acc_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_EOUT) |-> sts.pipe_idle)
    else $error("delta sent before the pipeline drained");

  a_no_issue_outside: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (state == S_EISS && s_cnt < ns))
    else $error("sample issued outside the evaluation loop");

endmodule

@@ hw/rtl/binder_loss_move_delta_core.sv @@
// Binder's loss move delta engine.
// Items arrive on a command channel: an item is taken at a rising edge where
// start is high and busy is low, and busy then stays high until the item has
// produced its last result. Each result appears for exactly one cycle with
// valid high; the receiver cannot stall it, so the block never waits on it.
// Loads of a label, weight or decision label answer with one result; a
// weight load first sums the weights of all samples in use.
// A move does a read-modify-write of two joint counts per sample through
// the single write port of the count memory.
// An evaluation of a valid item gives num_groups results, one per group: each
// group but the item's own and the empty groups after the first walks the samples
// through a four-stage read, multiply and accumulate pipeline, one sample per cycle.
// A rebuild clears the 16384-entry count memory, one entry per cycle, then
// recounts the group sizes and joint counts and sums the weights anew.
// After reset the count memory is cleared in a pass with busy held high;
// configuration writes on the APB port are taken at any time, but
// should only be made while the block is idle.
module binder_loss_move_delta_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    mode,
  input  logic [5:0]                    sample_index,
  input  logic [7:0]                    item_index,
  input  logic [3:0]                    group,
  input  logic [15:0]                   weight,
  output logic                          valid,
  output logic [3:0]                    target_group,
  output logic signed [34:0]            delta_scaled,
  output logic [21:0]                   total_weight,
  output logic                          status,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Configuration registers, reset to one.
  logic [6:0] num_samples;
  logic [8:0] num_items;
  logic [4:0] num_groups;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples <= 7'd1;
      num_items   <= 9'd1;
      num_groups  <= 5'd1;
    end else if (cfg_wr) begin
      case (int'(paddr[3:2]))
        bld_pkg::REG_NUM_SAMPLES: num_samples <= pwdata[6:0];
        bld_pkg::REG_NUM_ITEMS:   num_items   <= pwdata[8:0];
        bld_pkg::REG_NUM_GROUPS:  num_groups  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (int'(paddr[3:2]))
      bld_pkg::REG_NUM_SAMPLES: prdata = {25'd0, num_samples};
      bld_pkg::REG_NUM_ITEMS:   prdata = {23'd0, num_items};
      bld_pkg::REG_NUM_GROUPS:  prdata = {27'd0, num_groups};
      default:                  prdata = '0;
    endcase
  end

  // Each register is used clamped to the size of the stores.
  logic [6:0] ns;
  logic [8:0] ni;
  logic [4:0] ng;

  assign ns = (num_samples > 7'(bld_pkg::MAX_SAMPLES)) ? 7'(bld_pkg::MAX_SAMPLES) : num_samples;
  assign ni = (num_items > 9'(bld_pkg::MAX_ITEMS)) ? 9'(bld_pkg::MAX_ITEMS) : num_items;
  assign ng = (num_groups > 5'(bld_pkg::MAX_GROUPS)) ? 5'(bld_pkg::MAX_GROUPS) : num_groups;

  bld_pkg::cmd_t cmd;
  bld_pkg::sts_t sts;

  // The controller sequences every mode; the datapath holds all stores.
  bld_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ns    (ns),
    .ni    (ni),
    .ng    (ng),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bld_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (mode),
    .sample_index (sample_index),
    .item_index   (item_index),
    .group        (group),
    .weight       (weight),
    .ns           (ns),
    .ni           (ni),
    .ng           (ng),
    .sts          (sts),
    .valid        (valid),
    .target_group (target_group),
    .delta_scaled (delta_scaled),
    .total_weight (total_weight),
    .status       (status),
    .last         (last)
  );

endmodule

@@ sim/tb_binder_loss_move_delta_core.sv @@
module tb_binder_loss_move_delta_core;

  // Mode codes outside the defined set; both must be answered with an error.
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  // Longest silence that a correct block can produce is the count memory
  // clearing pass of a rebuild plus its recount, so the watchdog allows
  // several times that.
  localparam int QUIET_LIMIT = 80000;

  typedef struct {
    bit [3:0]  grp;
    bit [34:0] delta;
    bit [21:0] tot;
    bit        st;
    bit        lst;
  } delta_result_t;

  // The scoreboard carries its own copy of the label, weight and count stores.
  // Each accepted item updates that copy and queues the results it should
  // cause; each result from the block is checked against the oldest of them.
  class move_delta_board;
    bit [3:0]  smp_lab [64][256];
    bit [15:0] smp_wt  [64];
    bit [3:0]  dec_lab [256];
    bit [8:0]  grp_size[16];
    bit [8:0]  joint   [64][16][16];
    bit [21:0] wt_sum;
    bit        lab_set [64][256];
    bit        wt_set  [64];
    bit        dec_set [256];
    int        ns, ni, ng;
    int        errors;
    delta_result_t due[$];

    function void clear();
      foreach (grp_size[g]) grp_size[g] = '0;
      foreach (joint[s, g, l]) joint[s][g][l] = '0;
      foreach (lab_set[s, i]) lab_set[s][i] = 1'b0;
      foreach (wt_set[s]) wt_set[s] = 1'b0;
      foreach (dec_set[i]) dec_set[i] = 1'b0;
      wt_sum = '0;
      ns = 1;
      ni = 1;
      ng = 1;
      errors = 0;
    endfunction

    function void set_reg(int idx, int value);
      if (idx == bld_pkg::REG_NUM_SAMPLES)
        ns = (value > bld_pkg::MAX_SAMPLES) ? bld_pkg::MAX_SAMPLES : value;
      else if (idx == bld_pkg::REG_NUM_ITEMS)
        ni = (value > bld_pkg::MAX_ITEMS) ? bld_pkg::MAX_ITEMS : value;
      else if (idx == bld_pkg::REG_NUM_GROUPS)
        ng = (value > bld_pkg::MAX_GROUPS) ? bld_pkg::MAX_GROUPS : value;
    endfunction

    function void queue_result(int grp, bit [34:0] delta, bit st, bit lst);
      delta_result_t r;
      r.grp = grp[3:0];
      r.delta = delta;
      r.tot = wt_sum;
      r.st = st;
      r.lst = lst;
      due.push_back(r);
    endfunction

    function void resum_weights();
      bit [63:0] t;
      t = '0;
      for (int s = 0; s < ns; s++) t += 64'(smp_wt[s]);
      wt_sum = t[21:0];
    endfunction

    // Loss change, scaled by the total weight, for moving item i from g to h.
    function bit [34:0] move_gain(int i, int g, int h);
      bit [63:0] acc;
      bit [63:0] diff;
      int l;
      if (g == h) return '0;
      acc = 64'(wt_sum) * (64'(grp_size[h]) - 64'(grp_size[g]) - 64'd1);
      for (int s = 0; s < ns; s++) begin
        l = smp_lab[s][i];
        diff = 64'(joint[s][g][l]) - 64'(joint[s][h][l]);
        acc += 64'd2 * diff * 64'(smp_wt[s]);
      end
      return acc[34:0];
    endfunction

    function void note_item(bit [2:0] md, int si, int it, int grp, bit [15:0] w);
      int g;
      bit empty_seen;
      bit [34:0] d;
      case (md)
        bld_pkg::MODE_LD_LABEL: begin
          if (si >= ns || it >= ni || grp >= ng) begin
            queue_result(0, '0, 1'b1, 1'b1);
          end else begin
            smp_lab[si][it] = grp[3:0];
            lab_set[si][it] = 1'b1;
            queue_result(0, '0, 1'b0, 1'b1);
          end
        end
        bld_pkg::MODE_LD_WEIGHT: begin
          if (si >= ns) begin
            queue_result(0, '0, 1'b1, 1'b1);
          end else begin
            smp_wt[si] = w;
            wt_set[si] = 1'b1;
            resum_weights();
            queue_result(0, '0, 1'b0, 1'b1);
          end
        end
        bld_pkg::MODE_LD_DEC: begin
          if (it >= ni || grp >= ng) begin
            queue_result(0, '0, 1'b1, 1'b1);
          end else begin
            dec_lab[it] = grp[3:0];
            dec_set[it] = 1'b1;
            queue_result(0, '0, 1'b0, 1'b1);
          end
        end
        bld_pkg::MODE_REBUILD: begin
          foreach (grp_size[k]) grp_size[k] = '0;
          foreach (joint[s, a, b]) joint[s][a][b] = '0;
          for (int h = 0; h < ni; h++) begin
            g = dec_lab[h];
            grp_size[g] = grp_size[g] + 9'd1;
            for (int s = 0; s < ns; s++)
              joint[s][g][smp_lab[s][h]] = joint[s][g][smp_lab[s][h]] + 9'd1;
          end
          resum_weights();
          queue_result(0, '0, 1'b0, 1'b1);
        end
        bld_pkg::MODE_EVAL: begin
          if (it >= ni || dec_lab[it] >= ng) begin
            queue_result(0, '0, 1'b1, 1'b1);
          end else begin
            g = dec_lab[it];
            empty_seen = 1'b0;
            for (int h = 0; h < ng; h++) begin
              d = '0;
              if (grp_size[h] != 0) begin
                d = move_gain(it, g, h);
              end else if (!empty_seen) begin
                empty_seen = 1'b1;
                d = move_gain(it, g, h);
              end
              queue_result(h, d, 1'b0, h == ng - 1);
            end
          end
        end
        bld_pkg::MODE_MOVE: begin
          if (it >= ni || grp >= ng || dec_lab[it] >= ng) begin
            queue_result(0, '0, 1'b1, 1'b1);
          end else begin
            g = dec_lab[it];
            if (g != grp) begin
              dec_lab[it] = grp[3:0];
              grp_size[g] = grp_size[g] - 9'd1;
              grp_size[grp] = grp_size[grp] + 9'd1;
              for (int s = 0; s < ns; s++) begin
                joint[s][g][smp_lab[s][it]] = joint[s][g][smp_lab[s][it]] - 9'd1;
                joint[s][grp][smp_lab[s][it]] = joint[s][grp][smp_lab[s][it]] + 9'd1;
              end
            end
            queue_result(0, '0, 1'b0, 1'b1);
          end
        end
        default: queue_result(0, '0, 1'b1, 1'b1);
      endcase
    endfunction

    function void check_result(bit [3:0] grp, bit [34:0] delta, bit [21:0] tot, bit st,
                               bit lst);
      delta_result_t e;
      if (due.size() == 0) begin
        $error("result with no item outstanding: group %0d delta %0d", grp, $signed(delta));
        errors++;
        return;
      end
      e = due.pop_front();
      if (grp !== e.grp) begin
        $error("target_group: expected %0d, got %0d", e.grp, grp);
        errors++;
      end
      if (delta !== e.delta) begin
        $error("delta_scaled: expected %0d, got %0d", $signed(e.delta), $signed(delta));
        errors++;
      end
      if (tot !== e.tot) begin
        $error("total_weight: expected %0d, got %0d", e.tot, tot);
        errors++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
      if (lst !== e.lst) begin
        $error("last: expected %0d, got %0d", e.lst, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode = bld_pkg::MODE_LD_LABEL;
  logic [5:0]  sample_index = '0;
  logic [7:0]  item_index = '0;
  logic [3:0]  group = '0;
  logic [15:0] weight = '0;
  logic        valid;
  logic [3:0]  target_group;
  logic signed [34:0] delta_scaled;
  logic [21:0] total_weight;
  logic        status;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  move_delta_board board;
  int          idle_pct = 0;
  int          quiet = 0;

  binder_loss_move_delta_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .sample_index(sample_index), .item_index(item_index),
    .group(group), .weight(weight),
    .valid(valid), .target_group(target_group), .delta_scaled(delta_scaled),
    .total_weight(total_weight), .status(status), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results cannot be held off, so every strobe is checked at the edge that
  // ends its cycle. The block updates its outputs with nonblocking assignments,
  // so the values seen here are those of the cycle just ended.
  always @(posedge clk) begin
    if (!rst && valid)
      board.check_result(target_group, delta_scaled, total_weight, status, last);
  end

  // The watchdog counts cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Presents one item and returns at the edge where it is taken. Start is left
  // high afterwards, so that a following item with no gap keeps it high; it is
  // only lowered when a gap is drawn or the bench drains, which is always a later time step.
  task automatic send_item(bit [2:0] md, int si, int it, int grp, bit [15:0] w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= md;
    sample_index <= si[5:0];
    item_index <= it[7:0];
    group <= grp[3:0];
    weight <= w;
    do @(posedge clk); while (busy);
    board.note_item(md, si, it, grp, w);
  endtask

  // Holds the sender back until every expected result has come in and the
  // block has gone idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.due.size() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  // Setup cycle, then the access cycle; the register is taken at the edge
  // that ends the access cycle.
  task automatic write_reg(int idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(4 * idx);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, value);
  endtask

  task automatic configure(int n_smp, int n_itm, int n_grp);
    drain();
    write_reg(bld_pkg::REG_NUM_SAMPLES, n_smp);
    write_reg(bld_pkg::REG_NUM_ITEMS, n_itm);
    write_reg(bld_pkg::REG_NUM_GROUPS, n_grp);
    @(posedge clk);
  endtask

  // Writes every weight, label and decision label that the current sizes make
  // visible and that has never been written, so that no stale store is read.
  // A weight load sums every weight in use, so missing weights are written
  // with the sample count raised one step at a time.
  task automatic fill_stores();
    int target;
    target = board.ns;
    for (int s = 0; s < target; s++)
      if (!board.wt_set[s]) begin
        drain();
        write_reg(bld_pkg::REG_NUM_SAMPLES, s + 1);
        send_item(bld_pkg::MODE_LD_WEIGHT, s, 0, 0, 16'($urandom));
      end
    drain();
    write_reg(bld_pkg::REG_NUM_SAMPLES, target);
    for (int s = 0; s < board.ns; s++)
      for (int i = 0; i < board.ni; i++)
        if (!board.lab_set[s][i])
          send_item(bld_pkg::MODE_LD_LABEL, s, i, $urandom_range(board.ng - 1),
                    16'($urandom));
    for (int i = 0; i < board.ni; i++)
      if (!board.dec_set[i])
        send_item(bld_pkg::MODE_LD_DEC, 0, i, $urandom_range(board.ng - 1), 16'($urandom));
  endtask

  // Mostly in-range operands with random content; a share of wild indexes and
  // labels exercises the error paths.
  task automatic random_item();
    int pick, si, it, grp;
    bit [15:0] w;
    bit [2:0] md;
    si = ($urandom_range(99) < 85) ? $urandom_range(board.ns - 1) : $urandom_range(63);
    it = ($urandom_range(99) < 85) ? $urandom_range(board.ni - 1) : $urandom_range(255);
    grp = ($urandom_range(99) < 85) ? $urandom_range(board.ng - 1) : $urandom_range(15);
    case ($urandom_range(3))
      0: w = 16'hFFFF;
      1: w = 16'($urandom_range(15));
      default: w = 16'($urandom);
    endcase
    pick = $urandom_range(99);
    if (pick < 32) md = bld_pkg::MODE_EVAL;
    else if (pick < 64) md = bld_pkg::MODE_MOVE;
    else if (pick < 76) md = bld_pkg::MODE_LD_LABEL;
    else if (pick < 84) md = bld_pkg::MODE_LD_WEIGHT;
    else if (pick < 93) md = bld_pkg::MODE_LD_DEC;
    else if (pick < 96) md = bld_pkg::MODE_REBUILD;
    else if (pick < 98) md = MODE_SPARE_A;
    else md = MODE_SPARE_B;
    send_item(md, si, it, grp, w);
  endtask

  int shapes[8][3] = '{
    '{4, 16, 4}, '{64, 1, 16}, '{1, 24, 16}, '{8, 8, 8},
    '{2, 8, 2}, '{16, 4, 16}, '{40, 2, 3}, '{3, 16, 1}
  };

  initial begin
    board = new();
    board.clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items under the reset sizes of one sample, item and group.
    send_item(bld_pkg::MODE_LD_LABEL, 0, 0, 0, 16'h0000);
    send_item(bld_pkg::MODE_LD_WEIGHT, 0, 0, 0, 16'hFFFF);
    send_item(bld_pkg::MODE_LD_DEC, 0, 0, 0, 16'h0000);
    send_item(bld_pkg::MODE_REBUILD, 0, 0, 0, 16'h0000);
    send_item(bld_pkg::MODE_EVAL, 0, 0, 0, 16'h0000);
    send_item(bld_pkg::MODE_MOVE, 0, 0, 0, 16'h0000);      // move to its own group
    send_item(bld_pkg::MODE_LD_LABEL, 63, 255, 15, 16'hFFFF);
    send_item(bld_pkg::MODE_LD_WEIGHT, 1, 0, 0, 16'h1234);
    send_item(bld_pkg::MODE_LD_DEC, 0, 1, 0, 16'h0000);
    send_item(bld_pkg::MODE_EVAL, 0, 200, 0, 16'h0000);
    send_item(bld_pkg::MODE_MOVE, 0, 0, 9, 16'h0000);
    send_item(MODE_SPARE_A, 0, 0, 0, 16'h0000);
    send_item(MODE_SPARE_B, 63, 255, 15, 16'hFFFF);

    // Each phase sets new sizes, fills whatever has become visible, recounts
    // and then runs random items under its own amount of sender idling.
    for (int p = 0; p < 8; p++) begin
      configure(shapes[p][0], shapes[p][1], shapes[p][2]);
      idle_pct = 0;
      fill_stores();
      send_item(bld_pkg::MODE_REBUILD, 0, 0, 0, 16'h0000);
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 56;
        2: idle_pct = 32;
        default: idle_pct = 0;
      endcase
      if (p == 0) begin
        // An evaluation, a move of item 0 into group 3 and a second evaluation,
        // then an evaluation of the last item, 15.
        send_item(bld_pkg::MODE_EVAL, 0, 0, 0, 16'h0000);
        send_item(bld_pkg::MODE_MOVE, 0, 0, 3, 16'h0000);
        send_item(bld_pkg::MODE_EVAL, 0, 0, 0, 16'h0000);
        send_item(bld_pkg::MODE_EVAL, 0, 15, 0, 16'h0000);
      end
      repeat (20) random_item();
    end

    drain();
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
